// ===== src/fmbq_pkg.sv =====
// Shared opcodes and cell control type for the front/middle/back queue.
package fmbq_pkg;

  // Request opcodes
  localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT   = 3'd3;
  localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
  localparam logic [2:0] OP_POP_BACK    = 3'd5;

  // Width of stored values and of the reported level
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LEVEL_W = 7;

  // Per-cell control for one accepted beat
  typedef struct packed {
    logic load_in;    // take the pushed value
    logic load_prev;  // shift toward the back: take the front-side neighbor
    logic load_next;  // shift toward the front: take the back-side neighbor
    logic tap;        // this cell holds the popped value
    logic capture;    // refresh the tap register
  } cell_ctrl_t;

endpackage

// ===== src/fmbq_cell.sv =====
// One storage cell of the queue chain with its tap register for the pop path.
module fmbq_cell (
  input  logic                             clk_i,
  input  fmbq_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [fmbq_pkg::DATA_W-1:0] value_in_i,
  input  logic signed [fmbq_pkg::DATA_W-1:0] prev_i,
  input  logic signed [fmbq_pkg::DATA_W-1:0] next_i,
  output logic signed [fmbq_pkg::DATA_W-1:0] data_o,
  output logic signed [fmbq_pkg::DATA_W-1:0] leaf_o
);

  logic signed [fmbq_pkg::DATA_W-1:0] data_q, data_d;
  logic signed [fmbq_pkg::DATA_W-1:0] leaf_q, leaf_d;

  // Pick the next stored value: load, shift either way, or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load_in) begin
      data_d = value_in_i;
    end else if (ctrl_i.load_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.load_next) begin
      data_d = next_i;
    end
  end

  // Present the old value only from the cell being popped, zero elsewhere
  always_comb begin
    leaf_d = leaf_q;
    if (ctrl_i.capture) begin
      leaf_d = ctrl_i.tap ? data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    leaf_q <= leaf_d;
  end

  assign data_o = data_q;
  assign leaf_o = leaf_q;

endmodule

// ===== src/fmbq_or_tree.sv =====
// Registered binary OR tree that gathers the popped value from the cell taps.
module fmbq_or_tree #(
  parameter int unsigned LEAVES = 64,
  parameter int unsigned WIDTH  = 32
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic [WIDTH-1:0] root_o
);

  // Node j has children 2j and 2j+1; indices at or above LEAVES are leaves
  logic [WIDTH-1:0] node_q [1:LEAVES-1];

  for (genvar j = 1; j < LEAVES; j++) begin : g_node
    logic [WIDTH-1:0] left, right;
    if (2 * j >= LEAVES) begin : g_leaf
      assign left  = leaf_i[2 * j - LEAVES];
      assign right = leaf_i[2 * j + 1 - LEAVES];
    end else begin : g_inner
      assign left  = node_q[2 * j];
      assign right = node_q[2 * j + 1];
    end

    // Merge one level per cycle
    always_ff @(posedge clk_i) begin
      node_q[j] <= left | right;
    end
  end

  assign root_o = node_q[1];

endmodule

// ===== src/front_middle_back_queue.sv =====
// Queue with push and pop at front, middle and back, built as a shifting cell chain.
// Result path: the popped value goes through the cell tap register and then the registered OR tree.
// Requests: a new request is taken only after the result beat of the previous one leaves;
//   the controller waits for the registered OR tree that collects the popped value.
// Reset: the stored count clears to zero and the controller returns to idle at once;
//   cell contents stay undefined until written and are never read before that.
module front_middle_back_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         op_i,
  input  logic signed [fmbq_pkg::DATA_W-1:0] value_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fmbq_pkg::DATA_W-1:0] value_out_o,
  output logic                               pop_empty_o,
  output logic                               push_full_o,
  output logic [fmbq_pkg::LEVEL_W-1:0]       level_o
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned LG     = $clog2(DEPTH);
  localparam int unsigned LEAVES = 2 ** LG;
  localparam int unsigned TW     = $clog2(LG + 1);
  localparam int unsigned DW     = fmbq_pkg::DATA_W;
  localparam int unsigned LW     = fmbq_pkg::LEVEL_W;

  // Controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [TW-1:0] tick_q, tick_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop_empty_q, pop_empty_d;
  logic          push_full_q, push_full_d;
  logic [LW-1:0] level_q, level_d;

  logic          accept;
  logic          is_push, is_pop, full, empty, do_ins, do_rem;
  logic [CW-1:0] pos, last;
  logic [CW+LW-1:0] count_ext;

  logic signed [DW-1:0] data [DEPTH];
  logic signed [DW-1:0] leaf [DEPTH];
  logic        [DW-1:0] tree_leaf [LEAVES];
  logic        [DW-1:0] root;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign last   = count_q - CW'(1);

  // Decode the request and pick the insert or remove position
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos     = '0;
    unique case (op_i)
      fmbq_pkg::OP_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      fmbq_pkg::OP_PUSH_MIDDLE: begin
        is_push = 1'b1;
        pos     = count_q >> 1;
      end
      fmbq_pkg::OP_PUSH_BACK: begin
        is_push = 1'b1;
        pos     = count_q;
      end
      fmbq_pkg::OP_POP_FRONT: begin
        is_pop = 1'b1;
      end
      fmbq_pkg::OP_POP_MIDDLE: begin
        is_pop = 1'b1;
        pos    = last >> 1;
      end
      fmbq_pkg::OP_POP_BACK: begin
        is_pop = 1'b1;
        pos    = last;
      end
      default: begin
      end
    endcase
  end

  assign do_ins = accept && is_push && !full;
  assign do_rem = accept && is_pop && !empty;

  // Update the count and the result flags on the request beat
  always_comb begin
    count_d     = count_q;
    pop_empty_d = pop_empty_q;
    push_full_d = push_full_q;
    level_d     = level_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = last;
    end
    count_ext = {{LW{1'b0}}, count_d};
    if (accept) begin
      pop_empty_d = is_pop && empty;
      push_full_d = is_push && full;
      level_d     = count_ext[LW-1:0];
    end
  end

  // Cell chain: each cell takes its own shift decision from the position
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fmbq_pkg::cell_ctrl_t ctrl;
    logic signed [DW-1:0] prev, next;

    assign ctrl.load_in   = do_ins && (CW'(i) == pos);
    assign ctrl.load_prev = do_ins && (CW'(i) > pos);
    assign ctrl.load_next = do_rem && (CW'(i) >= pos) && (CW'(i) < last);
    assign ctrl.tap       = do_rem && (CW'(i) == pos);
    assign ctrl.capture   = accept;

    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_prev
      assign prev = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_next
      assign next = data[i+1];
    end

    fmbq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .value_in_i (value_in_i),
      .prev_i     (prev),
      .next_i     (next),
      .data_o     (data[i]),
      .leaf_o     (leaf[i])
    );
  end

  // Pad the tap row to a power of two with zero leaves
  for (genvar k = 0; k < LEAVES; k++) begin : g_pad
    if (k < DEPTH) begin : g_used
      assign tree_leaf[k] = leaf[k];
    end else begin : g_zero
      assign tree_leaf[k] = '0;
    end
  end

  fmbq_or_tree #(
    .LEAVES (LEAVES),
    .WIDTH  (DW)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (tree_leaf),
    .root_o (root)
  );

  // Sequence one request: accept, wait for the tree, hold the result beat
  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          tick_d  = TW'(LG);
        end
      end
      ST_RUN: begin
        tick_d = tick_q - TW'(1);
        if (tick_q == TW'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_empty_q <= pop_empty_d;
    push_full_q <= push_full_d;
    level_q     <= level_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign value_out_o = root;
  assign pop_empty_o = pop_empty_q;
  assign push_full_o = push_full_q;
  assign level_o     = level_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pop_empty_o && push_full_o))
    else $error("both empty and full flagged");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pop_empty_o || push_full_o)) |-> (value_out_o == '0))
    else $error("failed request returned a value");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the count");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

// ===== tb/front_middle_back_queue_test.sv =====
// Self-checking testbench for the front/middle/back queue with a queue-based predictor.
module front_middle_back_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned DW            = fmbq_pkg::DATA_W;
  localparam int unsigned LW            = fmbq_pkg::LEVEL_W;

  // Codes outside the operation set; the block treats them as no operation
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 empty;
    logic                 full;
    logic [LW-1:0]        level;
  } fmbq_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           op_i        = fmbq_pkg::OP_PUSH_FRONT;
  logic signed [DW-1:0] value_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [DW-1:0] value_out_o;
  logic                 pop_empty_o;
  logic                 push_full_o;
  logic [LW-1:0]        level_o;

  // Predictor state: stored values, front at index 0
  logic signed [DW-1:0] held_values[$];
  fmbq_result_t         results_due[$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  front_middle_back_queue #(.DEPTH(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_in_i (value_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_out_o(value_out_o),
    .pop_empty_o(pop_empty_o),
    .push_full_o(push_full_o),
    .level_o    (level_o)
  );

  // Toggle the clock every half period
  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Count a failure, report only the first few
  function automatic void note_failure(string msg);
    if (fail_count < REPORT_MAX) $display("%s", msg);
    fail_count++;
  endfunction

  // Apply one request to the predicted contents and queue the expected result
  function automatic void predict_request(logic [2:0] op, logic signed [DW-1:0] val);
    fmbq_result_t res;
    int unsigned  n;
    int unsigned  pos;
    res = '0;
    n   = held_values.size();
    case (op)
      fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK: begin
        if (n >= DEPTH) begin
          res.full = 1'b1;
        end else begin
          pos = (op == fmbq_pkg::OP_PUSH_FRONT) ? 0 :
                (op == fmbq_pkg::OP_PUSH_MIDDLE) ? n / 2 : n;
          if (pos == n) held_values = {held_values, val};
          else held_values.insert(pos, val);
        end
      end
      fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK: begin
        if (n == 0) begin
          res.empty = 1'b1;
        end else begin
          pos = (op == fmbq_pkg::OP_POP_FRONT) ? 0 :
                (op == fmbq_pkg::OP_POP_MIDDLE) ? (n - 1) / 2 : n - 1;
          res.value = held_values[pos];
          held_values.delete(pos);
        end
      end
      default: ;
    endcase
    res.level = LW'(held_values.size());
    results_due = {results_due, res};
  endfunction

  // Check every result beat against the oldest expectation
  always @(negedge clk_i) begin : check_results
    fmbq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d empty %0b full %0b level %0d",
                               value_out_o, pop_empty_o, push_full_o, level_o));
      end else begin
        want = results_due[0];
        results_due.delete(0);
        if (value_out_o !== want.value || pop_empty_o !== want.empty ||
            push_full_o !== want.full || level_o !== want.level) begin
          note_failure($sformatf({"mismatch: expected value %0d empty %0b full %0b level %0d,",
                                  " got value %0d empty %0b full %0b level %0d"},
                                 want.value, want.empty, want.full, want.level,
                                 value_out_o, pop_empty_o, push_full_o, level_o));
        end
      end
    end
  end

  // Drive one request beat; entered and left right after a rising edge
  task automatic send_request(input logic [2:0] op, input logic signed [DW-1:0] val);
    bit taken;
    // hold off the beat for a random gap
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_in_i <= val;
    // wait until the beat is taken; stall is settled by the falling edge
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) predict_request(op, val);
      @(posedge clk_i);
    end
  endtask

  // Random value with the extremes favored
  function automatic logic signed [DW-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push_op();
    case ($urandom_range(0, 2))
      0:       return fmbq_pkg::OP_PUSH_FRONT;
      1:       return fmbq_pkg::OP_PUSH_MIDDLE;
      default: return fmbq_pkg::OP_PUSH_BACK;
    endcase
  endfunction

  function automatic logic [2:0] pick_pop_op();
    case ($urandom_range(0, 2))
      0:       return fmbq_pkg::OP_POP_FRONT;
      1:       return fmbq_pkg::OP_POP_MIDDLE;
      default: return fmbq_pkg::OP_POP_BACK;
    endcase
  endfunction

  // Empty pops, unused codes, extremes and each position on short queues
  task automatic test_directed();
    send_request(fmbq_pkg::OP_POP_FRONT, VAL_MAX);
    send_request(fmbq_pkg::OP_POP_MIDDLE, VAL_MIN);
    send_request(fmbq_pkg::OP_POP_BACK, -1);
    send_request(OP_UNUSED_6, VAL_MIN);
    send_request(OP_UNUSED_7, VAL_MAX);
    send_request(fmbq_pkg::OP_PUSH_MIDDLE, '0);
    send_request(fmbq_pkg::OP_POP_MIDDLE, VAL_MAX);
    send_request(fmbq_pkg::OP_PUSH_BACK, VAL_MAX);
    send_request(fmbq_pkg::OP_PUSH_FRONT, VAL_MIN);
    send_request(fmbq_pkg::OP_PUSH_MIDDLE, -1);
    send_request(fmbq_pkg::OP_PUSH_MIDDLE, 32'sh5555_5555);
    send_request(fmbq_pkg::OP_PUSH_BACK, 32'shAAAA_AAAA);
    send_request(OP_UNUSED_6, 32'sh1234_5678);
    send_request(fmbq_pkg::OP_POP_MIDDLE, '0);
    send_request(fmbq_pkg::OP_POP_MIDDLE, '0);
    send_request(OP_UNUSED_7, -1);
    send_request(fmbq_pkg::OP_POP_BACK, '0);
    send_request(fmbq_pkg::OP_POP_FRONT, '0);
    send_request(fmbq_pkg::OP_POP_MIDDLE, '0);
    send_request(fmbq_pkg::OP_POP_BACK, '0);
    send_request(fmbq_pkg::OP_PUSH_FRONT, 32'sd1);
    send_request(fmbq_pkg::OP_POP_BACK, VAL_MIN);
  endtask

  // Fill to the top with mostly pushes, overflow, then drain past empty
  task automatic test_fill_drain();
    while (held_values.size() < DEPTH) begin
      if ($urandom_range(0, 99) < 85) send_request(pick_push_op(), rand_value());
      else send_request(pick_pop_op(), rand_value());
    end
    repeat (3) send_request(pick_push_op(), rand_value());
    while (held_values.size() > 0) begin
      if ($urandom_range(0, 99) < 85) send_request(pick_pop_op(), rand_value());
      else send_request(pick_push_op(), rand_value());
    end
    repeat (3) send_request(pick_pop_op(), rand_value());
  endtask

  // Mixed traffic with the push share shifting every few dozen beats
  task automatic test_random_mix(input int unsigned beats);
    int unsigned push_share;
    int unsigned roll;
    push_share = 50;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 25 == 0) push_share = 25 * $urandom_range(1, 3);
      roll = $urandom_range(0, 99);
      if (roll < 3) send_request($urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6, rand_value());
      else if (roll < 3 + push_share) send_request(pick_push_op(), rand_value());
      else send_request(pick_pop_op(), rand_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();

    // no idling
    test_fill_drain();
    test_random_mix(50);

    // sender mostly idle
    idle_pct  = 77;
    stall_pct = 0;
    test_fill_drain();
    test_random_mix(50);

    // receiver mostly stalling
    idle_pct  = 0;
    stall_pct = 77;
    test_fill_drain();
    test_random_mix(50);

    // light idling on both sides
    idle_pct  = 16;
    stall_pct = 16;
    test_fill_drain();
    test_random_mix(50);

    // drop valid and wait out the last results
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fmbq_pkg.sv
src/fmbq_cell.sv
src/fmbq_or_tree.sv
src/front_middle_back_queue.sv
tb/front_middle_back_queue_test.sv
